// File: hdl/tspf_pkg.sv
`default_nettype none

package tspf_pkg;

   // Table sizes used as defaults on the top level.
   localparam int POLICY_ENTRIES_DEF = 16;
   localparam int FLOW_ENTRIES_DEF   = 64;
   localparam int DROP_ENTRIES_DEF   = 64;

   // Protocol numbers and TCP flag positions.
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] FLAGS_PURE_SYN = 8'h02;
   localparam int FLAG_RST_BIT = 2;
   localparam int FLAG_ACK_BIT = 4;

   // Handshake steps held in a flow entry.
   localparam logic [1:0] STEP_SYN    = 2'd0;
   localparam logic [1:0] STEP_SYNACK = 2'd1;
   localparam logic [1:0] STEP_ACK    = 2'd2;

   // Request operation codes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_FILTER = 1'b1;

   // Canonical tuple: low address, high address, low port, high port, protocol.
   localparam int TUPLE_W  = 104;
   localparam int POLICY_W = TUPLE_W + 2;
   localparam int FLOW_W   = TUPLE_W + 64 + 4;
   localparam int DROP_W   = TUPLE_W;

   typedef struct packed {
      logic        operation;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  tcp_flags;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic        policy_action;
      logic [3:0]  policy_slot;
   } req_payload_type;

   typedef struct packed {
      logic pass_packet;
      logic table_full;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      TBL_DROP   = 2'd0,
      TBL_POLICY = 2'd1,
      TBL_FLOW   = 2'd2
   } table_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          capture;
      logic          scan_start;
      logic          scan_run;
      table_sel_type tbl;
      logic          load_wr;
      logic          flow_upd;
      logic          drop_ins;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic drop_hit;
      logic is_load;
      logic is_tcp;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/tspf_req_if.sv
`default_nettype none

interface tspf_req_if;
   logic                     valid;
   logic                     ready;
   tspf_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tspf_rsp_if.sv
`default_nettype none

interface tspf_rsp_if;
   logic                     valid;
   logic                     ready;
   tspf_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tcp_stateful_packet_filter_unit.sv
`default_nettype none

// Channel  Direction  Handshake          Content
// req_ch   in         valid/ready        policy load or packet to filter
// rsp_ch   out        valid/ready        pass decision and table-full flag
// csr      in         write enable only  default action
//
// A TCP packet walks the drop cache, the policy table and the flow table in turn; other
// packets skip the flow walk, a drop-cache hit ends after the first walk, and a policy
// load writes its slot without any walk. Each table is walked one entry a cycle through
// its RAM read port.
// One request is in flight at a time; the result is held until rsp_ch is ready.
// Reset is synchronous and clears all valid bits and the default action.

module tcp_stateful_packet_filter_unit #(
   parameter int POLICY_ENTRIES = tspf_pkg::POLICY_ENTRIES_DEF,
   parameter int FLOW_ENTRIES   = tspf_pkg::FLOW_ENTRIES_DEF,
   parameter int DROP_ENTRIES   = tspf_pkg::DROP_ENTRIES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   tspf_req_if.sink     req_ch,
   tspf_rsp_if.source   rsp_ch,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);
   import tspf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing of the table walks.
   tspf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, compares and updates.
   tspf_dpath #(
      .POLICY_ENTRIES (POLICY_ENTRIES),
      .FLOW_ENTRIES   (FLOW_ENTRIES),
      .DROP_ENTRIES   (DROP_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_ch.data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_ch.data)
   );

   // A request is never taken while a result is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while a result waits");

   // After a request is accepted the block is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("block ready straight after accepting a request");

   // A delivered result is not offered again.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> !rsp_ch.valid)
      else $error("result repeated");

endmodule

`default_nettype wire

// File: hdl/tspf_ram.sv
`default_nettype none

module tspf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/tspf_ctrl.sv
`default_nettype none

module tspf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire tspf_pkg::dp_status_type status,
   output tspf_pkg::dp_cmd_type         cmd
);
   import tspf_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_LOAD     = 8'b0000_0100,
      S_DSCAN    = 8'b0000_1000,
      S_PSCAN    = 8'b0001_0000,
      S_FSCAN    = 8'b0010_0000,
      S_FUPD     = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.tbl   = TBL_DROP;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_load) begin
               state_in = S_LOAD;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_DSCAN;
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_RESP;
         end
         S_DSCAN: begin
            cmd.scan_run = 1'b1;
            cmd.tbl      = TBL_DROP;
            if (status.scan_done) begin
               cmd.scan_start = 1'b1;
               state_in       = status.drop_hit ? S_RESP : S_PSCAN;
            end
         end
         S_PSCAN: begin
            cmd.scan_run = 1'b1;
            cmd.tbl      = TBL_POLICY;
            if (status.scan_done) begin
               cmd.scan_start = 1'b1;
               if (status.is_tcp) begin
                  state_in = S_FSCAN;
               end else begin
                  cmd.drop_ins = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end
         S_FSCAN: begin
            cmd.scan_run = 1'b1;
            cmd.tbl      = TBL_FLOW;
            if (status.scan_done) begin
               state_in = S_FUPD;
            end
         end
         S_FUPD: begin
            cmd.flow_upd = 1'b1;
            cmd.drop_ins = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tspf_dpath.sv
`default_nettype none

module tspf_dpath #(
   parameter int POLICY_ENTRIES = tspf_pkg::POLICY_ENTRIES_DEF,
   parameter int FLOW_ENTRIES   = tspf_pkg::FLOW_ENTRIES_DEF,
   parameter int DROP_ENTRIES   = tspf_pkg::DROP_ENTRIES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tspf_pkg::req_payload_type req_data,
   input  wire logic                      csr_write_enable,
   input  wire logic                      csr_write_data,
   input  wire tspf_pkg::dp_cmd_type      cmd,
   output tspf_pkg::dp_status_type        status,
   output tspf_pkg::rsp_payload_type      rsp_data
);
   import tspf_pkg::*;

   localparam int MAXN = (POLICY_ENTRIES > FLOW_ENTRIES)
                         ? ((POLICY_ENTRIES > DROP_ENTRIES) ? POLICY_ENTRIES : DROP_ENTRIES)
                         : ((FLOW_ENTRIES > DROP_ENTRIES) ? FLOW_ENTRIES : DROP_ENTRIES);
   localparam int CW  = $clog2(MAXN + 1);
   localparam int PIW = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;
   localparam int FIW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int DIW = (DROP_ENTRIES > 1) ? $clog2(DROP_ENTRIES) : 1;

   // Captured request, configuration and per-packet results.
   req_payload_type req_ff;
   logic default_action_ff;
   logic action_ff, action_in;
   logic full_ff, full_in;
   logic pol_found_ff, pol_found_in;
   logic drop_hit_ff, drop_hit_in;
   logic drop_free_ff, drop_free_in;
   logic [DIW-1:0] drop_fidx_ff, drop_fidx_in;
   logic flow_hit_ff, flow_hit_in;
   logic flow_free_ff, flow_free_in;
   logic [FIW-1:0] flow_hidx_ff, flow_hidx_in;
   logic [FIW-1:0] flow_fidx_ff, flow_fidx_in;
   logic [63:0] flow_seqs_ff, flow_seqs_in;
   logic [3:0] flow_st_ff, flow_st_in;

   // Scan sequencer.
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic pend_ff, pend_in;
   logic [CW-1:0] limit;

   // Valid bits.
   logic [POLICY_ENTRIES-1:0] pol_vld_ff;
   logic [FLOW_ENTRIES-1:0]   flow_vld_ff;
   logic [DROP_ENTRIES-1:0]   drop_vld_ff;

   // Memory ports.
   logic [POLICY_W-1:0] pol_rd, pol_wd;
   logic [FLOW_W-1:0]   flow_rd, flow_wd;
   logic [DROP_W-1:0]   drop_rd;
   logic pol_we, flow_we, drop_we;
   logic [PIW-1:0] pol_waddr;
   logic [FIW-1:0] flow_waddr;

   // Canonical form of the captured packet.
   logic fwd, is_tcp, has_ports;
   logic [31:0] lo_ip, hi_ip;
   logic [15:0] sp, dp, lp, hp, raw_lp, raw_hp;
   logic [TUPLE_W-1:0] key;
   logic slot_ok;

   assign fwd       = req_ff.src_ip < req_ff.dst_ip;
   assign lo_ip     = fwd ? req_ff.src_ip : req_ff.dst_ip;
   assign hi_ip     = fwd ? req_ff.dst_ip : req_ff.src_ip;
   assign is_tcp    = req_ff.protocol == PROTO_TCP;
   assign has_ports = is_tcp || (req_ff.protocol == PROTO_UDP);
   assign sp        = has_ports ? req_ff.src_port : 16'd0;
   assign dp        = has_ports ? req_ff.dst_port : 16'd0;
   assign lp        = fwd ? sp : dp;
   assign hp        = fwd ? dp : sp;
   assign raw_lp    = fwd ? req_ff.src_port : req_ff.dst_port;
   assign raw_hp    = fwd ? req_ff.dst_port : req_ff.src_port;
   assign key       = {lo_ip, hi_ip, lp, hp, req_ff.protocol};
   assign slot_ok   = 32'(req_ff.policy_slot) < POLICY_ENTRIES;

   // Entry comparisons for the entry read in the previous cycle.
   logic pol_match, flow_match, drop_match, flow_empty, drop_empty;
   assign pol_match  = pol_vld_ff[pidx_ff[PIW-1:0]]
                       && (pol_rd[POLICY_W-1:2] == key) && (pol_rd[1] == fwd);
   assign flow_match = flow_vld_ff[pidx_ff[FIW-1:0]] && (flow_rd[FLOW_W-1:68] == key);
   assign drop_match = drop_vld_ff[pidx_ff[DIW-1:0]] && (drop_rd == key);
   assign flow_empty = !flow_vld_ff[pidx_ff[FIW-1:0]];
   assign drop_empty = !drop_vld_ff[pidx_ff[DIW-1:0]];

   always_comb begin
      case (cmd.tbl)
         TBL_DROP:   limit = CW'(DROP_ENTRIES);
         TBL_POLICY: limit = CW'(POLICY_ENTRIES);
         TBL_FLOW:   limit = CW'(FLOW_ENTRIES);
         default:    limit = '0;
      endcase
   end

   // Handshake tracking on a found flow.
   logic [1:0] step;
   logic ffwd, ack_set, rst_set;
   logic [31:0] cseq, sseq;
   assign step    = flow_st_ff[1:0];
   assign ffwd    = flow_st_ff[2];
   assign cseq    = flow_seqs_ff[63:32];
   assign sseq    = flow_seqs_ff[31:0];
   assign ack_set = req_ff.tcp_flags[FLAG_ACK_BIT];
   assign rst_set = req_ff.tcp_flags[FLAG_RST_BIT];

   // Next values of the sequencer and the per-packet results.
   always_comb begin
      cnt_in        = cnt_ff;
      pidx_in       = pidx_ff;
      pend_in       = pend_ff;
      action_in     = action_ff;
      full_in       = full_ff;
      pol_found_in  = pol_found_ff;
      drop_hit_in   = drop_hit_ff;
      drop_free_in  = drop_free_ff;
      drop_fidx_in  = drop_fidx_ff;
      flow_hit_in   = flow_hit_ff;
      flow_free_in  = flow_free_ff;
      flow_hidx_in  = flow_hidx_ff;
      flow_fidx_in  = flow_fidx_ff;
      flow_seqs_in  = flow_seqs_ff;
      flow_st_in    = flow_st_ff;
      flow_we       = 1'b0;
      flow_waddr    = flow_hit_ff ? flow_hidx_ff : flow_fidx_ff;
      flow_wd       = {key, flow_seqs_ff, flow_st_ff};
      drop_we       = 1'b0;

      if (cmd.capture) begin
         action_in    = default_action_ff;
         full_in      = 1'b0;
         pol_found_in = 1'b0;
         drop_hit_in  = 1'b0;
         drop_free_in = 1'b0;
         flow_hit_in  = 1'b0;
         flow_free_in = 1'b0;
      end

      // Walk one entry a cycle; compare in the cycle after the read.
      if (cmd.scan_run) begin
         if (pend_ff) begin
            case (cmd.tbl)
               TBL_DROP: begin
                  if (drop_match) begin
                     drop_hit_in = 1'b1;
                  end
                  if (drop_empty && !drop_free_ff) begin
                     drop_free_in = 1'b1;
                     drop_fidx_in = pidx_ff[DIW-1:0];
                  end
               end
               TBL_POLICY: begin
                  if (pol_match && !pol_found_ff) begin
                     pol_found_in = 1'b1;
                     action_in    = pol_rd[0];
                  end
               end
               TBL_FLOW: begin
                  if (flow_match && !flow_hit_ff) begin
                     flow_hit_in  = 1'b1;
                     flow_hidx_in = pidx_ff[FIW-1:0];
                     flow_seqs_in = flow_rd[67:4];
                     flow_st_in   = flow_rd[3:0];
                  end
                  if (flow_empty && !flow_free_ff) begin
                     flow_free_in = 1'b1;
                     flow_fidx_in = pidx_ff[FIW-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         if (cnt_ff != limit) begin
            cnt_in  = cnt_ff + CW'(1);
            pidx_in = cnt_ff;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.scan_start) begin
         cnt_in  = '0;
         pend_in = 1'b0;
      end

      // Flow table update for a TCP packet, then the drop-cache insert.
      if (cmd.flow_upd) begin
         if (flow_hit_ff) begin
            if (rst_set) begin
               action_in = action_ff;
            end else if (step == STEP_SYN) begin
               if (ack_set && (req_ff.ack_number == cseq + 32'd1) && (fwd != ffwd)) begin
                  flow_we   = 1'b1;
                  flow_wd   = {key, cseq, req_ff.seq_number,
                               flow_st_ff[3], fwd, STEP_SYNACK};
                  action_in = 1'b1;
               end else begin
                  action_in = 1'b0;
               end
            end else if ((step == STEP_SYNACK) && (fwd != ffwd)) begin
               if (ack_set && (req_ff.ack_number == sseq + 32'd1)) begin
                  flow_we   = 1'b1;
                  flow_wd   = {key, req_ff.seq_number, sseq, 1'b1, fwd, STEP_ACK};
                  action_in = 1'b1;
               end
            end else begin
               action_in = flow_st_ff[3];
            end
         end else if ((req_ff.tcp_flags == FLAGS_PURE_SYN) && action_ff) begin
            if (flow_free_ff) begin
               flow_we = 1'b1;
               flow_wd = {key, req_ff.seq_number, 32'd0, 1'b1, fwd, STEP_SYN};
            end else begin
               full_in = 1'b1;
            end
         end
      end
      if (cmd.drop_ins && !action_in) begin
         if (drop_free_ff) begin
            drop_we = 1'b1;
         end else begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_action_ff <= 1'b0;
         pol_vld_ff        <= '0;
         flow_vld_ff       <= '0;
         drop_vld_ff       <= '0;
         pend_ff           <= 1'b0;
         cnt_ff            <= '0;
      end else begin
         if (csr_write_enable) begin
            default_action_ff <= csr_write_data;
         end
         if (pol_we) begin
            pol_vld_ff[pol_waddr] <= 1'b1;
         end
         if (cmd.flow_upd && flow_hit_ff && rst_set) begin
            flow_vld_ff[flow_hidx_ff] <= 1'b0;
         end else if (flow_we) begin
            flow_vld_ff[flow_waddr] <= 1'b1;
         end
         if (drop_we) begin
            drop_vld_ff[drop_fidx_ff] <= 1'b1;
         end
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      pidx_ff      <= pidx_in;
      action_ff    <= action_in;
      full_ff      <= full_in;
      pol_found_ff <= pol_found_in;
      drop_hit_ff  <= drop_hit_in;
      drop_free_ff <= drop_free_in;
      drop_fidx_ff <= drop_fidx_in;
      flow_hit_ff  <= flow_hit_in;
      flow_free_ff <= flow_free_in;
      flow_hidx_ff <= flow_hidx_in;
      flow_fidx_ff <= flow_fidx_in;
      flow_seqs_ff <= flow_seqs_in;
      flow_st_ff   <= flow_st_in;
   end

   // Policy loads.
   assign pol_we    = cmd.load_wr && slot_ok;
   assign pol_waddr = PIW'(req_ff.policy_slot);
   assign pol_wd    = {lo_ip, hi_ip, raw_lp, raw_hp, req_ff.protocol, fwd,
                       req_ff.policy_action};

   tspf_ram #(.WIDTH(POLICY_W), .DEPTH(POLICY_ENTRIES)) u_policy_ram (
      .clock   (clock),
      .wr_en   (pol_we),
      .wr_addr (pol_waddr),
      .wr_data (pol_wd),
      .rd_addr (cnt_ff[PIW-1:0]),
      .rd_data (pol_rd)
   );

   tspf_ram #(.WIDTH(FLOW_W), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
      .clock   (clock),
      .wr_en   (flow_we),
      .wr_addr (flow_waddr),
      .wr_data (flow_wd),
      .rd_addr (cnt_ff[FIW-1:0]),
      .rd_data (flow_rd)
   );

   tspf_ram #(.WIDTH(DROP_W), .DEPTH(DROP_ENTRIES)) u_drop_ram (
      .clock   (clock),
      .wr_en   (drop_we),
      .wr_addr (drop_fidx_ff),
      .wr_data (key),
      .rd_addr (cnt_ff[DIW-1:0]),
      .rd_data (drop_rd)
   );

   // Status and result.
   assign status.scan_done = cmd.scan_run && (cnt_ff == limit) && !pend_ff;
   assign status.drop_hit  = drop_hit_ff;
   assign status.is_load   = req_ff.operation == OP_LOAD;
   assign status.is_tcp    = is_tcp;

   assign rsp_data.pass_packet = (req_ff.operation == OP_FILTER) && !drop_hit_ff && action_ff;
   assign rsp_data.table_full  = full_ff;

endmodule

`default_nettype wire

// File: test/tb_tcp_stateful_packet_filter_unit.sv
`timescale 1ns / 1ps

module tb_tcp_stateful_packet_filter_unit;
   import tspf_pkg::*;

   localparam int POL_N = POLICY_ENTRIES_DEF;
   localparam int FLOW_N = FLOW_ENTRIES_DEF;
   localparam int DROP_N = DROP_ENTRIES_DEF;
   localparam logic [7:0] F_SYN = 8'h02;
   localparam logic [7:0] F_RST = 8'h04;
   localparam logic [7:0] F_ACK = 8'h10;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam int SETTLE_CYCLES = 250;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   tspf_req_if req_ch ();
   tspf_rsp_if rsp_ch ();

   tcp_stateful_packet_filter_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Mirror of the filter's tables and register.
   logic          mirror_default;
   logic          pol_valid [POL_N];
   logic [103:0]  pol_key [POL_N];
   logic          pol_fwd [POL_N];
   logic          pol_act [POL_N];
   logic          flow_valid [FLOW_N];
   logic [103:0]  flow_key [FLOW_N];
   logic [31:0]   flow_cseq [FLOW_N];
   logic [31:0]   flow_sseq [FLOW_N];
   logic [1:0]    flow_step [FLOW_N];
   logic          flow_fwd [FLOW_N];
   logic          flow_act [FLOW_N];
   logic          drop_valid [DROP_N];
   logic [103:0]  drop_key [DROP_N];

   rsp_payload_type verdict_q [$];
   int errors = 0;
   logic idle_on = 1'b1;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   longint cycles = 0;

   // Works out the verdict of one request and updates the mirrored tables.
   function automatic rsp_payload_type filter_verdict(req_payload_type r);
      logic          fwd;
      logic [31:0]   lo, hi;
      logic [15:0]   sp, dp, lp, hp;
      logic [103:0]  key;
      logic          act, full;
      int            f, e;
      rsp_payload_type v;
      fwd = r.src_ip < r.dst_ip;
      lo = fwd ? r.src_ip : r.dst_ip;
      hi = fwd ? r.dst_ip : r.src_ip;
      sp = r.src_port;
      dp = r.dst_port;
      v = '0;
      if (r.operation == OP_LOAD) begin
         lp = fwd ? sp : dp;
         hp = fwd ? dp : sp;
         pol_valid[r.policy_slot] = 1'b1;
         pol_key[r.policy_slot] = {lo, hi, lp, hp, r.protocol};
         pol_fwd[r.policy_slot] = fwd;
         pol_act[r.policy_slot] = r.policy_action;
         return v;
      end
      // Ports count only for TCP and UDP.
      if (r.protocol != PROTO_TCP && r.protocol != PROTO_UDP) begin
         sp = '0;
         dp = '0;
      end
      lp = fwd ? sp : dp;
      hp = fwd ? dp : sp;
      key = {lo, hi, lp, hp, r.protocol};
      for (int i = 0; i < DROP_N; i++)
         if (drop_valid[i] && drop_key[i] == key) return v;
      act = mirror_default;
      full = 1'b0;
      for (int i = 0; i < POL_N; i++) begin
         if (pol_valid[i] && pol_key[i] == key && pol_fwd[i] == fwd) begin
            act = pol_act[i];
            break;
         end
      end
      if (r.protocol == PROTO_TCP) begin
         f = -1;
         for (int i = 0; i < FLOW_N; i++)
            if (f < 0 && flow_valid[i] && flow_key[i] == key) f = i;
         if (f >= 0) begin
            if (r.tcp_flags[FLAG_RST_BIT]) begin
               flow_valid[f] = 1'b0;
            end else if (flow_step[f] == STEP_SYN) begin
               if (r.tcp_flags[FLAG_ACK_BIT] && r.ack_number == 32'(flow_cseq[f] + 1)
                   && fwd != flow_fwd[f]) begin
                  flow_sseq[f] = r.seq_number;
                  flow_step[f] = STEP_SYNACK;
                  flow_fwd[f] = fwd;
                  act = 1'b1;
               end else begin
                  act = 1'b0;
               end
            end else if (flow_step[f] == STEP_SYNACK && fwd != flow_fwd[f]) begin
               if (r.tcp_flags[FLAG_ACK_BIT] && r.ack_number == 32'(flow_sseq[f] + 1)) begin
                  flow_cseq[f] = r.seq_number;
                  flow_step[f] = STEP_ACK;
                  flow_fwd[f] = fwd;
                  flow_act[f] = 1'b1;
                  act = 1'b1;
               end
            end else begin
               act = flow_act[f];
            end
         end else if (r.tcp_flags == FLAGS_PURE_SYN && act) begin
            e = -1;
            for (int i = 0; i < FLOW_N; i++)
               if (e < 0 && !flow_valid[i]) e = i;
            if (e < 0) begin
               full = 1'b1;
            end else begin
               flow_valid[e] = 1'b1;
               flow_key[e] = key;
               flow_cseq[e] = r.seq_number;
               flow_step[e] = STEP_SYN;
               flow_fwd[e] = fwd;
               flow_act[e] = 1'b1;
            end
         end
      end
      // A dropped packet goes into the drop cache when there is room.
      if (!act) begin
         e = -1;
         for (int i = 0; i < DROP_N; i++)
            if (e < 0 && !drop_valid[i]) e = i;
         if (e < 0) begin
            full = 1'b1;
         end else begin
            drop_valid[e] = 1'b1;
            drop_key[e] = key;
         end
      end
      v.pass_packet = act;
      v.table_full = full;
      return v;
   endfunction

   function automatic req_payload_type mk(logic op, logic [31:0] sip, logic [31:0] dip,
                                          logic [7:0] proto, logic [15:0] sp,
                                          logic [15:0] dp, logic [7:0] flags,
                                          logic [31:0] seq, logic [31:0] ack,
                                          logic pact, logic [3:0] slot);
      req_payload_type r;
      r.operation = op;
      r.src_ip = sip;
      r.dst_ip = dip;
      r.protocol = proto;
      r.src_port = sp;
      r.dst_port = dp;
      r.tcp_flags = flags;
      r.seq_number = seq;
      r.ack_number = ack;
      r.policy_action = pact;
      r.policy_slot = slot;
      return r;
   endfunction

   // Offers one request and waits for it to be taken; the expectation is
   // either typed in or worked out by the predictor.
   task automatic send_request(req_payload_type r, logic known = 1'b0,
                               rsp_payload_type typed = '0);
      rsp_payload_type v;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data = r;
      do @(posedge clock); while (!req_ch.ready);
      v = filter_verdict(r);
      verdict_q.insert(verdict_q.size(), known ? typed : v);
      // Withdraw the request so that it is not taken a second time.
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_default(logic value);
      wait (verdict_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      req_ch.valid = 1'b0;
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mirror_default = value;
   endtask

   // Address and port pools, so that tuples meet again.
   function automatic logic [31:0] pick_ip();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h0a00_0001;
         3: return 32'h0a00_0002;
         4: return 32'hc0a8_0105;
         5: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'd80;
         3: return 16'd443;
         default: return 16'($urandom());
      endcase
   endfunction

   // A random TCP conversation: optional policy, the three-way handshake with
   // the odd broken step, some data, and often a reset at the end.
   task automatic tcp_session(inout int sent);
      logic [31:0] cip, sip, cseq, sseq;
      logic [15:0] cport, sport;
      logic        bad;
      cip = pick_ip();
      sip = pick_ip();
      cport = pick_port();
      sport = pick_port();
      cseq = $urandom();
      sseq = $urandom();
      if ($urandom_range(0, 3) != 0) begin
         send_request(mk(OP_LOAD, cip, sip, PROTO_TCP, cport, sport, 8'h00, $urandom(),
                         $urandom(), $urandom_range(0, 7) != 0, 4'($urandom())));
         sent++;
      end
      send_request(mk(OP_FILTER, cip, sip, PROTO_TCP, cport, sport, F_SYN, cseq,
                      $urandom(), 1'($urandom()), 4'($urandom())));
      bad = $urandom_range(0, 5) == 0;
      send_request(mk(OP_FILTER, sip, cip, PROTO_TCP, sport, cport, F_SYN | F_ACK, sseq,
                      bad ? $urandom() : cseq + 1, 1'($urandom()), 4'($urandom())));
      bad = $urandom_range(0, 5) == 0;
      send_request(mk(OP_FILTER, bad ? sip : cip, bad ? cip : sip, PROTO_TCP,
                      bad ? sport : cport, bad ? cport : sport, F_ACK, cseq + 1,
                      sseq + 1, 1'($urandom()), 4'($urandom())));
      sent += 3;
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1))
            send_request(mk(OP_FILTER, cip, sip, PROTO_TCP, cport, sport, 8'h18,
                            $urandom(), $urandom(), 1'($urandom()), 4'($urandom())));
         else
            send_request(mk(OP_FILTER, sip, cip, PROTO_TCP, sport, cport, 8'h18,
                            $urandom(), $urandom(), 1'($urandom()), 4'($urandom())));
         sent++;
      end
      if ($urandom_range(0, 9) < 6) begin
         send_request(mk(OP_FILTER, cip, sip, PROTO_TCP, cport, sport,
                         F_RST | 8'($urandom_range(0, 1) << 4), $urandom(), $urandom(),
                         1'($urandom()), 4'($urandom())));
         sent++;
      end
   endtask

   // Anything at all: random loads and packets of any protocol and flags.
   function automatic req_payload_type noise_request();
      req_payload_type r;
      r = req_payload_type'({$urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom()});
      if ($urandom_range(0, 1)) begin
         r.src_ip = pick_ip();
         r.dst_ip = pick_ip();
         r.src_port = pick_port();
         r.dst_port = pick_port();
      end
      case ($urandom_range(0, 4))
         0: r.protocol = PROTO_TCP;
         1: r.protocol = PROTO_UDP;
         2: r.protocol = PROTO_ICMP;
         default: ;
      endcase
      if ($urandom_range(0, 4) != 0) r.operation = OP_FILTER;
      return r;
   endfunction

   // Receiver: random stall bursts, and one long hold-off on request.
   int stall_left = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_left = 600;
         hold_done = 1'b1;
      end
      if (reset) begin
         rsp_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result pass_packet=%0b table_full=%0b", $time,
                     rsp_ch.data.pass_packet, rsp_ch.data.table_full);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_ch.data.pass_packet !== want.pass_packet) begin
               $display("%0t: pass_packet expected %0b actual %0b", $time,
                        want.pass_packet, rsp_ch.data.pass_packet);
               errors++;
            end
            if (rsp_ch.data.table_full !== want.table_full) begin
               $display("%0t: table_full expected %0b actual %0b", $time,
                        want.table_full, rsp_ch.data.table_full);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   typedef struct {
      req_payload_type r;
      logic            known;
      rsp_payload_type v;
   } stim_row_type;

   stim_row_type stim_table [$];

   initial begin
      int sent;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      mirror_default = 1'b0;
      for (int i = 0; i < POL_N; i++) pol_valid[i] = 1'b0;
      for (int i = 0; i < FLOW_N; i++) flow_valid[i] = 1'b0;
      for (int i = 0; i < DROP_N; i++) drop_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part; the default action is drop after reset.
      stim_table = '{
         '{mk(OP_FILTER, 32'h0, 32'hffff_ffff, PROTO_UDP, 16'hffff, 16'h0, 8'h0, 32'h0,
              32'h0, 1'b0, 4'h0), 1'b1, '0},
         '{mk(OP_LOAD, 32'h1, 32'h2, PROTO_TCP, 16'd1000, 16'd80, 8'h0, 32'h0, 32'h0,
              1'b1, 4'hf), 1'b1, '0},
         '{mk(OP_LOAD, 32'h5, 32'h6, PROTO_ICMP, 16'd7, 16'd9, 8'h0, 32'h0, 32'h0,
              1'b1, 4'h0), 1'b1, '0},
         '{mk(OP_FILTER, 32'h5, 32'h6, PROTO_ICMP, 16'd7, 16'd9, 8'h0, 32'h0, 32'h0,
              1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h1, 32'h2, PROTO_TCP, 16'd1000, 16'd80, F_SYN, 32'hffff_ffff,
              32'h0, 1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h2, 32'h1, PROTO_TCP, 16'd80, 16'd1000, F_SYN | F_ACK,
              32'h1234, 32'h0, 1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h1, 32'h2, PROTO_TCP, 16'd1000, 16'd80, F_ACK, 32'h0,
              32'h1235, 1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h2, 32'h1, PROTO_TCP, 16'd80, 16'd1000, 8'h18, 32'h9,
              32'h9, 1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h1, 32'h2, PROTO_TCP, 16'd1000, 16'd80, F_RST, 32'h0,
              32'h0, 1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_FILTER, 32'h0, 32'hffff_ffff, PROTO_UDP, 16'hffff, 16'h0, 8'h0, 32'h0,
              32'h0, 1'b0, 4'h0), 1'b1, '0},
         '{mk(OP_FILTER, 32'h7, 32'h7, PROTO_TCP, 16'd3, 16'd4, F_SYN, 32'h0, 32'h0,
              1'b0, 4'h0), 1'b0, '0},
         '{mk(OP_LOAD, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff, 16'hffff, 8'hff,
              32'hffff_ffff, 32'hffff_ffff, 1'b1, 4'hf), 1'b1, '0},
         '{mk(OP_FILTER, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff, 16'hffff, 8'hff,
              32'hffff_ffff, 32'hffff_ffff, 1'b1, 4'hf), 1'b0, '0}
      };
      foreach (stim_table[i]) send_request(stim_table[i].r, stim_table[i].known,
                                            stim_table[i].v);

      // Random part over several default-action settings.
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_default(1'(phase % 2 == 1));
         if (phase == 0) hold_req = 1'b1;
         if (phase == 3) idle_on = 1'b1;
         while (sent < 325 * (phase + 1)) begin
            if (phase == 3 && sent > 1200) idle_on = 1'b0;
            if (sent % 150 == 149) wait (verdict_q.size() == 0);
            if ($urandom_range(0, 9) < 7) begin
               tcp_session(sent);
            end else begin
               send_request(noise_request());
               sent++;
            end
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (verdict_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
